### src/hls_to_rgb_converter_unit_defines.svh
// Assertion macros for the HLS to RGB converter checker.
// Used by hrc_checker.sv; expects clk and rst_n in scope.
`ifndef HLS_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HLS_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Antecedent implies consequent, checked outside reset.
`define HRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrc: implication check failed");

// Condition must never hold outside reset.
`define HRC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hrc: forbidden condition seen");

`endif

### src/hrc_pkg.sv
// Package for the HLS to RGB converter: widths, types, constants, helpers.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package hrc_pkg;

  localparam int HUE_W   = 15;
  localparam int Q_W     = 13;
  localparam int MULB_W  = Q_W + 1;
  localparam int LPRD_W  = Q_W + MULB_W;
  localparam int Q_FRAC  = 12;
  localparam int ANG_W   = 16;
  localparam int LVL_W   = 18;
  localparam int PRD_W   = 30;
  localparam int DIV_SH  = 6;
  localparam int MAG_W   = 23;
  localparam int RCP_W   = 24;
  localparam int RCP_SH  = 27;
  localparam int QMUL_W  = MAG_W + RCP_W;
  localparam int QUO_W   = 20;
  localparam int RES_W   = 21;
  localparam int NCH     = 3;
  localparam int LATENCY = 6;

  localparam int Q_ONE   = 4096;
  localparam int Q_HALF  = 2048;
  localparam int DEG60   = 960;
  localparam int DEG120  = 1920;
  localparam int DEG180  = 2880;
  localparam int DEG240  = 3840;
  localparam int DEG360  = 5760;

  // ceil(2^27 / 15); exact floor division for values below 2^24
  localparam logic [RCP_W-1:0] RECIP15 = 24'd8947849;

  typedef logic signed [HUE_W-1:0]  hue_t;
  typedef logic        [Q_W-1:0]    q12_t;
  typedef logic        [MULB_W-1:0] mulb_t;
  typedef logic        [LPRD_W-1:0] lprod_t;
  typedef logic signed [ANG_W-1:0]  angle_t;
  typedef logic signed [LVL_W-1:0]  level_t;
  typedef logic signed [PRD_W-1:0]  prod_t;
  typedef logic        [MAG_W-1:0]  mag_t;
  typedef logic        [QMUL_W-1:0] qmul_t;
  typedef logic        [QUO_W-1:0]  quo_t;
  typedef logic signed [RES_W-1:0]  res_t;

  typedef enum logic [1:0] {
    SEC_RISE,
    SEC_HIGH,
    SEC_FALL,
    SEC_LOW
  } sector_t;

  function automatic angle_t wrap_angle(input angle_t a);
    angle_t w;
    w = a;
    if (w > angle_t'(DEG360)) begin
      w = w - angle_t'(DEG360);
    end else if (w < angle_t'(0)) begin
      w = w + angle_t'(DEG360);
    end
    return w;
  endfunction

  function automatic sector_t classify(input angle_t h);
    sector_t s;
    if (h < angle_t'(DEG60)) begin
      s = SEC_RISE;
    end else if (h < angle_t'(DEG180)) begin
      s = SEC_HIGH;
    end else if (h < angle_t'(DEG240)) begin
      s = SEC_FALL;
    end else begin
      s = SEC_LOW;
    end
    return s;
  endfunction

  // multiplier operand of the linear ramps
  function automatic angle_t ramp_arg(input angle_t h, input sector_t s);
    angle_t t;
    if (s == SEC_FALL) begin
      t = angle_t'(DEG240) - h;
    end else begin
      t = h;
    end
    return t;
  endfunction

  function automatic q12_t clamp_q12(input res_t v);
    q12_t c;
    if (v < res_t'(0)) begin
      c = '0;
    end else if (v > res_t'(Q_ONE)) begin
      c = q12_t'(Q_ONE);
    end else begin
      c = q12_t'(v);
    end
    return c;
  endfunction

endpackage

### src/hls_to_rgb_converter_unit.sv
// HLS to RGB color converter, six-stage pipeline.
// Depends on hrc_pkg.
//
// Usage:
//   Input: drive in_hue (signed, 1/16 degree), in_lightness and
//   in_saturation (Q12) with start high; an item is taken at each rising
//   edge where start is high and busy is low. busy stays low, so one item
//   can enter every cycle.
//   Output: out_valid marks out_red/out_green/out_blue (Q12) for exactly
//   one cycle. There is no backpressure; results must be taken as shown.
// Throughput: 1 item per cycle.
// Stages: m2 product and hue wrap, m2/sector select, m1 and ramp slope,
//   slope multiply, divide by 960 via reciprocal multiply, ramp sum and
//   clamp into the output register.
// Reset: synchronous, active low; clears all stage valid bits, so items in
//   flight are dropped and out_valid goes low.
`timescale 1ns / 1ps

module hls_to_rgb_converter_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hrc_pkg::hue_t in_hue,
  input  hrc_pkg::q12_t in_lightness,
  input  hrc_pkg::q12_t in_saturation,
  output logic          out_valid,
  output hrc_pkg::q12_t out_red,
  output hrc_pkg::q12_t out_green,
  output hrc_pkg::q12_t out_blue
);
  import hrc_pkg::*;

  logic accept;

  // stage A: lightness product, wrapped hue per channel
  mulb_t   mul_b;
  angle_t  ang_base;
  lprod_t  a_prod_nxt;
  angle_t  a_ang_nxt [NCH];
  logic    a_vld_r;
  logic    a_gray_r;
  q12_t    a_l_r, a_s_r;
  lprod_t  a_prod_r;
  angle_t  a_ang_r [NCH];

  // stage B: m2, sector and ramp operand
  logic [LPRD_W-Q_FRAC-1:0] prod_hi;
  level_t  b_m2_nxt;
  sector_t b_sec_nxt [NCH];
  angle_t  b_t_nxt [NCH];
  logic    b_vld_r;
  logic    b_gray_r;
  q12_t    b_l_r;
  level_t  b_m2_r;
  sector_t b_sec_r [NCH];
  angle_t  b_t_r [NCH];

  // stage C: m1 and slope
  level_t  c_m1_nxt, c_diff_nxt;
  logic    c_vld_r;
  logic    c_gray_r;
  q12_t    c_l_r;
  level_t  c_m1_r, c_m2_r, c_diff_r;
  sector_t c_sec_r [NCH];
  angle_t  c_t_r [NCH];

  // stage D: slope products
  prod_t   d_p_nxt [NCH];
  logic    d_vld_r;
  logic    d_gray_r;
  q12_t    d_l_r;
  level_t  d_m1_r, d_m2_r;
  sector_t d_sec_r [NCH];
  prod_t   d_p_r [NCH];

  // stage E: quotient magnitude and sign
  prod_t   abs_p [NCH];
  mag_t    mag [NCH];
  qmul_t   qmul [NCH];
  quo_t    e_q_nxt [NCH];
  logic    e_vld_r;
  logic    e_gray_r;
  q12_t    e_l_r;
  level_t  e_m1_r, e_m2_r;
  sector_t e_sec_r [NCH];
  quo_t    e_q_r [NCH];
  logic    e_neg_r [NCH];

  // stage F: output register
  res_t    sq [NCH];
  res_t    val [NCH];
  q12_t    out_ch_nxt [NCH];
  logic    out_valid_r;
  q12_t    out_red_r, out_green_r, out_blue_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    if (in_lightness < q12_t'(Q_HALF)) begin
      mul_b = mulb_t'(Q_ONE) + mulb_t'(in_saturation);
    end else begin
      mul_b = mulb_t'(in_saturation);
    end
    a_prod_nxt   = lprod_t'(in_lightness) * lprod_t'(mul_b);
    ang_base     = angle_t'(in_hue);
    a_ang_nxt[0] = wrap_angle(ang_base + angle_t'(DEG120));
    a_ang_nxt[1] = wrap_angle(ang_base);
    a_ang_nxt[2] = wrap_angle(ang_base - angle_t'(DEG120));
  end

  always_comb begin
    prod_hi = a_prod_r[LPRD_W-1:Q_FRAC];
    if (a_l_r < q12_t'(Q_HALF)) begin
      b_m2_nxt = level_t'(prod_hi);
    end else begin
      b_m2_nxt = level_t'(a_l_r) + level_t'(a_s_r) - level_t'(prod_hi);
    end
    for (int i = 0; i < NCH; i++) begin
      b_sec_nxt[i] = classify(a_ang_r[i]);
      b_t_nxt[i]   = ramp_arg(a_ang_r[i], b_sec_nxt[i]);
    end
  end

  always_comb begin
    c_m1_nxt   = (level_t'(b_l_r) <<< 1) - b_m2_r;
    c_diff_nxt = (b_m2_r - level_t'(b_l_r)) <<< 1;
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      d_p_nxt[i] = prod_t'(c_diff_r) * prod_t'(c_t_r[i]);
    end
  end

  // truncating divide by 960 = 64 * 15 on the magnitude
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      abs_p[i]   = d_p_r[i][PRD_W-1] ? -d_p_r[i] : d_p_r[i];
      mag[i]     = mag_t'(abs_p[i] >> DIV_SH);
      qmul[i]    = qmul_t'(mag[i]) * qmul_t'(RECIP15);
      e_q_nxt[i] = quo_t'(qmul[i] >> RCP_SH);
    end
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      sq[i] = e_neg_r[i] ? -res_t'(e_q_r[i]) : res_t'(e_q_r[i]);
      case (e_sec_r[i]) inside
        SEC_RISE, SEC_FALL: val[i] = res_t'(e_m1_r) + sq[i];
        SEC_HIGH:           val[i] = res_t'(e_m2_r);
        default:            val[i] = res_t'(e_m1_r);
      endcase
      if (e_gray_r) begin
        out_ch_nxt[i] = clamp_q12(res_t'(e_l_r));
      end else begin
        out_ch_nxt[i] = clamp_q12(val[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      e_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_vld_r     <= accept;
      b_vld_r     <= a_vld_r;
      c_vld_r     <= b_vld_r;
      d_vld_r     <= c_vld_r;
      e_vld_r     <= d_vld_r;
      out_valid_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_gray_r <= (in_saturation == '0);
    a_l_r    <= in_lightness;
    a_s_r    <= in_saturation;
    a_prod_r <= a_prod_nxt;
    a_ang_r  <= a_ang_nxt;

    b_gray_r <= a_gray_r;
    b_l_r    <= a_l_r;
    b_m2_r   <= b_m2_nxt;
    b_sec_r  <= b_sec_nxt;
    b_t_r    <= b_t_nxt;

    c_gray_r <= b_gray_r;
    c_l_r    <= b_l_r;
    c_m1_r   <= c_m1_nxt;
    c_m2_r   <= b_m2_r;
    c_diff_r <= c_diff_nxt;
    c_sec_r  <= b_sec_r;
    c_t_r    <= b_t_r;

    d_gray_r <= c_gray_r;
    d_l_r    <= c_l_r;
    d_m1_r   <= c_m1_r;
    d_m2_r   <= c_m2_r;
    d_sec_r  <= c_sec_r;
    d_p_r    <= d_p_nxt;

    e_gray_r <= d_gray_r;
    e_l_r    <= d_l_r;
    e_m1_r   <= d_m1_r;
    e_m2_r   <= d_m2_r;
    e_sec_r  <= d_sec_r;
    e_q_r    <= e_q_nxt;
    for (int i = 0; i < NCH; i++) begin
      e_neg_r[i] <= d_p_r[i][PRD_W-1];
    end

    out_red_r   <= out_ch_nxt[0];
    out_green_r <= out_ch_nxt[1];
    out_blue_r  <= out_ch_nxt[2];
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

### src/hrc_checker.sv
// Port-level checker for the HLS to RGB converter, bound to the top level.
// Depends on hrc_pkg and hls_to_rgb_converter_unit_defines.svh.
`timescale 1ns / 1ps
`include "hls_to_rgb_converter_unit_defines.svh"

module hrc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input hrc_pkg::q12_t in_saturation,
  input logic          out_valid,
  input hrc_pkg::q12_t out_red,
  input hrc_pkg::q12_t out_green,
  input hrc_pkg::q12_t out_blue
);
  import hrc_pkg::*;

  logic item_taken;
  logic gray_item;
  logic rgb_equal;
  logic rgb_over;

  assign item_taken = start && !busy;
  assign gray_item  = item_taken && (in_saturation == '0);
  assign rgb_equal  = (out_red == out_green) && (out_green == out_blue);
  assign rgb_over   = (out_red > q12_t'(Q_ONE)) || (out_green > q12_t'(Q_ONE))
                   || (out_blue > q12_t'(Q_ONE));

  // every result traces back to an item taken earlier
  `HRC_ASSERT_IMP(a_out_has_item, out_valid, $past(item_taken, LATENCY))

  // every item taken yields a result
  `HRC_ASSERT_IMP(a_item_has_out, item_taken, ##LATENCY out_valid)

  // zero saturation gives a gray result
  `HRC_ASSERT_IMP(a_gray_out, gray_item, ##LATENCY rgb_equal)

  `HRC_ASSERT_NEVER(a_out_range, out_valid && rgb_over)

endmodule

bind hls_to_rgb_converter_unit hrc_checker u_hrc_checker (.*);
